FILE: rtl/core/bytecode_operand_stack_top_macros.svh
// Assertion macros for the operand stack RTL.
`ifndef BYTECODE_OPERAND_STACK_TOP_MACROS_SVH
`define BYTECODE_OPERAND_STACK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold.
`define BOS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("operand stack check failed");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define BOS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("operand stack check failed");

`else

`define BOS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BOS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/bos_pkg.sv
// Shared types and codes of the operand stack.
package bos_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;

  // request codes
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_DUMP = 3'd1;
  localparam logic [2:0] OP_POP  = 3'd2;
  localparam logic [2:0] OP_SWAP = 3'd3;
  localparam logic [2:0] OP_PEEK = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd1;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd2;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd3;
  localparam logic [2:0] ST_PUSH_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [2:0]               status;
    logic                     last;
  } rsp_t;

endpackage

FILE: rtl/core/bos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bytecode_operand_stack_top.sv
// Operand stack top level: request sequencer around the entry RAM.
//
//   channel | valid     | stall     | payload | per transfer
//   --------+-----------+-----------+---------+-----------------------------
//   request | req_valid | req_stall | req     | one push/dump/pop/swap/peek
//   result  | rsp_valid | rsp_stall | rsp     | one status/value item
//
// Steps: push, pop and peek are accepted, then executed on the
// registered RAM read. Swap makes two reads and two writes through the
// single RAM write port, or only accept and execute when fewer than two
// entries are held. Dump makes one RAM read per entry, no result when empty.
// Reset: rst clears entry count, sequencer and result valid;
// the RAM itself is not cleared, entries above the count are never used.
// Stalls: the result register holds while rsp_stall is high; the sequencer
// waits in the state that emits the result until the result register frees.
`include "bytecode_operand_stack_top_macros.svh"

module bytecode_operand_stack_top
  import bos_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWAP2 = 2'd2;
  localparam logic [1:0] S_SWAP3 = 2'd3;

  logic [1:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     idx, idx_next;      // address of entry under work
  logic [2:0]        op;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] top_hold;           // top entry held during swap
  logic              top_ld;

  // RAM port
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  // result register
  logic              rsp_load;
  rsp_t              rsp_next;
  logic              can_emit;

  logic [CW-1:0]     cnt_m1;
  logic              full, empty, short;

  bos_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign cnt_m1    = count - CW'(1);
  assign full      = (count == CW'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign short     = (count < CW'(2));
  assign can_emit  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // One request at a time: every RAM write finishes before the next
  // request is taken, so reads never race a pending write.
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    top_ld     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = val;
    rd_en      = 1'b0;
    rd_addr    = cnt_m1[AW-1:0];
    rsp_load   = 1'b0;
    rsp_next.out_value = '0;
    rsp_next.status    = ST_OK;
    rsp_next.last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          // fetch the top entry right away; idx starts at top
          rd_en      = 1'b1;
          idx_next   = cnt_m1[AW-1:0];
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op)
          OP_PUSH: begin
            if (can_emit) begin
              rsp_load   = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                rsp_next.status = ST_PUSH_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
          end
          OP_POP: begin
            if (can_emit) begin
              rsp_load   = 1'b1;
              state_next = S_IDLE;
              if (empty) begin
                rsp_next.status = ST_POP_EMPTY;
              end else begin
                count_next = cnt_m1;
              end
            end
          end
          OP_PEEK: begin
            if (can_emit) begin
              rsp_load   = 1'b1;
              state_next = S_IDLE;
              if (empty) begin
                rsp_next.status = ST_PEEK_EMPTY;
              end else begin
                rsp_next.out_value = rd_data;
              end
            end
          end
          OP_SWAP: begin
            if (short) begin
              if (can_emit) begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_SWAP_SHORT;
                state_next      = S_IDLE;
              end
            end else begin
              // keep top, fetch the entry below it
              top_ld     = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = idx - AW'(1);
              state_next = S_SWAP2;
            end
          end
          OP_DUMP: begin
            if (empty) begin
              state_next = S_IDLE;
            end else if (can_emit) begin
              rsp_load           = 1'b1;
              rsp_next.out_value = rd_data;
              rsp_next.last      = (idx == '0);
              if (idx == '0) begin
                state_next = S_IDLE;
              end else begin
                // fetch the next entry down while this one goes into the result register
                rd_en    = 1'b1;
                rd_addr  = idx - AW'(1);
                idx_next = idx - AW'(1);
              end
            end
          end
          default: begin
            state_next = S_IDLE;   // unused codes give no result
          end
        endcase
      end
      S_SWAP2: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rd_data;
        state_next = S_SWAP3;
      end
      S_SWAP3: begin
        // rewriting the same entry while stalled is harmless
        wr_en   = 1'b1;
        wr_addr = idx - AW'(1);
        wr_data = top_hold;
        if (can_emit) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == S_IDLE && req_valid) begin
      op  <= req.req_type;
      val <= req.push_value;
    end
    if (top_ld) begin
      top_hold <= rd_data;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `BOS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(STACK_DEPTH))
  `BOS_ASSERT_IMP(a_port_excl, clk, rst, wr_en, !rd_en)
  `BOS_ASSERT_IMP(a_emit_state, clk, rst, rsp_load, state == S_EXEC || state == S_SWAP3)
  `BOS_ASSERT_IMP(a_emit_free, clk, rst, rsp_load, can_emit)
  `BOS_ASSERT_NXT(a_push_inc, clk, rst, state == S_EXEC && op == OP_PUSH && can_emit && !full, count == $past(count) + CW'(1))

endmodule

FILE: bench/bos_tb_pkg.sv
// Scoreboard class: predicts operand stack results and checks them in order.
package bos_tb_pkg;
  import bos_pkg::*;

  class stack_scoreboard;
    logic signed [DATA_W-1:0] entries [STACK_DEPTH_DEF];
    int unsigned              depth;
    rsp_t                     pending_results [$];
    int unsigned              error_count;

    function new();
      depth = 0;
      error_count = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      error_count++;
    endtask

    function rsp_t make_rsp(logic signed [DATA_W-1:0] value, logic [2:0] code, logic fin);
      rsp_t r;
      r.out_value = value;
      r.status    = code;
      r.last      = fin;
      return r;
    endfunction

    // Apply one accepted request to the shadow stack and queue its results.
    function void predict_results(req_t r);
      logic signed [DATA_W-1:0] tmp;
      case (r.req_type)
        OP_PUSH: begin
          if (depth >= STACK_DEPTH_DEF) begin
            pending_results.push_back(make_rsp('0, ST_PUSH_FULL, 1'b1));
          end else begin
            entries[depth] = r.push_value;
            depth++;
            pending_results.push_back(make_rsp('0, ST_OK, 1'b1));
          end
        end
        OP_DUMP: begin
          // top first, last flag on the bottom entry; nothing when empty
          for (int i = depth; i > 0; i--)
            pending_results.push_back(make_rsp(entries[i-1], ST_OK, i == 1));
        end
        OP_POP: begin
          if (depth == 0) begin
            pending_results.push_back(make_rsp('0, ST_POP_EMPTY, 1'b1));
          end else begin
            depth--;
            pending_results.push_back(make_rsp('0, ST_OK, 1'b1));
          end
        end
        OP_SWAP: begin
          if (depth < 2) begin
            pending_results.push_back(make_rsp('0, ST_SWAP_SHORT, 1'b1));
          end else begin
            tmp              = entries[depth-1];
            entries[depth-1] = entries[depth-2];
            entries[depth-2] = tmp;
            pending_results.push_back(make_rsp('0, ST_OK, 1'b1));
          end
        end
        OP_PEEK: begin
          if (depth == 0)
            pending_results.push_back(make_rsp('0, ST_PEEK_EMPTY, 1'b1));
          else
            pending_results.push_back(make_rsp(entries[depth-1], ST_OK, 1'b1));
        end
        default: ;
      endcase
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                  got.out_value, got.status, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.out_value !== want.out_value)
          report_mismatch($sformatf("out_value got %0d want %0d",
                                    got.out_value, want.out_value));
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
      end
    endtask

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_bytecode_operand_stack_top.sv
// Top-level testbench for the operand stack: stimulus, pacing and checking.
module tb_bytecode_operand_stack_top;
  import bos_pkg::*;
  import bos_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned HOLD_SEGMENT = 20;     // receiver segment that holds off
  localparam int unsigned HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int unsigned DRAIN_LIMIT  = 20000;  // cycles to wait for outstanding results
  localparam int unsigned TAIL_CYCLES  = 150;    // covers a full dump

  typedef enum logic [1:0] {MODE_GROW, MODE_SHRINK, MODE_CHURN} mix_mode_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  stack_scoreboard sb;

  mix_mode_t   mix_mode;
  int unsigned edge_hits;
  int unsigned churn_left;
  int unsigned burst_left;

  bytecode_operand_stack_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: both channels sampled at the rising edge. A request transfer is
  // fed to the predictor before any result of the same edge is checked; new
  // expectations go to the back of the queue so the order cannot matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.predict_results(req);
      if (rsp_valid && !rsp_stall)
        sb.check_result(rsp);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks start and end at a falling edge, so the payload
  // and valid change only there.
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the transfer happens.
  task automatic drive_item(req_t item);
    req_valid = 1'b1;
    req       = item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Bursts of random length; between bursts a random gap, sometimes none.
  // Now and then a long burst gives a stretch with no sender idling.
  task automatic offer(req_t item);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    drive_item(item);
  endtask

  function automatic req_t mk_req(logic [2:0] op, logic signed [DATA_W-1:0] v);
    req_t r;
    r.req_type   = op;
    r.push_value = v;
    return r;
  endfunction

  // Operand mix: both extremes, small values around zero, full random words.
  function automatic logic signed [DATA_W-1:0] random_operand();
    int v;
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: begin
        v = $urandom_range(0, 15);
        return DATA_W'(v - 8);
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] weighted_op(int unsigned w_push, int unsigned w_pop,
                                             int unsigned w_swap, int unsigned w_peek);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < w_push) return OP_PUSH;
    if (roll < w_push + w_pop) return OP_POP;
    if (roll < w_push + w_pop + w_swap) return OP_SWAP;
    if (roll < w_push + w_pop + w_swap + w_peek) return OP_PEEK;
    return OP_DUMP;
  endfunction

  // Random requests steered by the predicted depth: grow to full and push
  // a few more into the full stack, shrink to empty and keep popping a bit,
  // then churn around the middle. A few percent are unused codes (noise).
  function automatic req_t pick_random_request();
    req_t r;
    case (mix_mode)
      MODE_GROW: begin
        if (sb.depth == STACK_DEPTH_DEF) edge_hits++;
        if (edge_hits > 3) begin
          mix_mode  = MODE_SHRINK;
          edge_hits = 0;
        end
      end
      MODE_SHRINK: begin
        if (sb.depth == 0) edge_hits++;
        if (edge_hits > 3) begin
          mix_mode   = MODE_CHURN;
          edge_hits  = 0;
          churn_left = $urandom_range(20, 60);
        end
      end
      default: begin
        if (churn_left == 0)
          mix_mode = ($urandom_range(0, 1) != 0) ? MODE_GROW : MODE_SHRINK;
        else
          churn_left--;
      end
    endcase

    r.push_value = random_operand();
    if ($urandom_range(0, 99) < 3) begin
      r.req_type = 3'(OP_PEEK + $urandom_range(1, 3));
    end else begin
      case (mix_mode)
        MODE_GROW:   r.req_type = weighted_op(75, 8, 7, 7);
        MODE_SHRINK: r.req_type = weighted_op(10, 70, 8, 8);
        default:     r.req_type = weighted_op(30, 30, 15, 17);
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own, with one long hold-off while the
  // sender keeps offering, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned segment;
    int unsigned len;
    rsp_stall = 1'b0;
    segment   = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      segment++;
      len = $urandom_range(5, 40);
      if (segment == HOLD_SEGMENT) begin
        repeat (HOLD_CYCLES) begin
          rsp_stall = 1'b1;
          @(negedge clk);
        end
      end else begin
        case ($urandom_range(0, 2))
          0: repeat (len) begin            // free running
            rsp_stall = 1'b0;
            @(negedge clk);
          end
          1: repeat (len) begin            // scattered random stalls
            rsp_stall = ($urandom_range(0, 99) < 40);
            @(negedge clk);
          end
          default: repeat (len / 4 + 1) begin  // stall runs and free runs
            repeat ($urandom_range(1, 6)) begin
              rsp_stall = 1'b1;
              @(negedge clk);
            end
            repeat ($urandom_range(1, 4)) begin
              rsp_stall = 1'b0;
              @(negedge clk);
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_t        directed_q [$];
    req_t        item;
    int unsigned issued;
    int unsigned wait_cycles;

    sb         = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    mix_mode   = MODE_GROW;
    edge_hits  = 0;
    churn_left = 0;
    burst_left = 0;
    issued     = 0;

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: errors on an empty stack, dump of an empty stack (no
    // transfer out), swap with one entry, extreme operands, swap/peek/dump
    // ordering, pop, unused codes that must be ignored.
    directed_q.push_back(mk_req(OP_PEEK, 32'h1234_5678));
    directed_q.push_back(mk_req(OP_POP,  32'hffff_ffff));
    directed_q.push_back(mk_req(OP_SWAP, 32'h0));
    directed_q.push_back(mk_req(OP_DUMP, 32'h8000_0000));
    directed_q.push_back(mk_req(OP_PUSH, 32'h7fff_ffff));
    directed_q.push_back(mk_req(OP_SWAP, 32'h0));
    directed_q.push_back(mk_req(OP_PEEK, 32'h0));
    directed_q.push_back(mk_req(OP_PUSH, 32'h8000_0000));
    directed_q.push_back(mk_req(OP_PUSH, 32'h0000_0000));
    directed_q.push_back(mk_req(OP_PUSH, 32'hffff_ffff));
    directed_q.push_back(mk_req(OP_SWAP, 32'h0));
    directed_q.push_back(mk_req(OP_PEEK, 32'h0));
    directed_q.push_back(mk_req(OP_DUMP, 32'h0));
    directed_q.push_back(mk_req(OP_POP,  32'h0));
    directed_q.push_back(mk_req(3'(OP_PEEK + 1), 32'h5555_5555));
    directed_q.push_back(mk_req(3'(OP_PEEK + 2), 32'haaaa_aaaa));
    directed_q.push_back(mk_req(3'(OP_PEEK + 3), 32'hffff_ffff));
    directed_q.push_back(mk_req(OP_PEEK, 32'h0));
    directed_q.push_back(mk_req(OP_PUSH, 32'h5555_5555));
    directed_q.push_back(mk_req(OP_PUSH, 32'haaaa_aaaa));
    directed_q.push_back(mk_req(OP_DUMP, 32'h0));
    directed_q.push_back(mk_req(OP_POP,  32'h0));
    directed_q.push_back(mk_req(OP_PEEK, 32'h0));
    foreach (directed_q[i]) offer(directed_q[i]);

    // Random part; ignored codes are not counted.
    while (issued < RANDOM_ITEMS) begin
      item = pick_random_request();
      if (item.req_type <= OP_PEEK) issued++;
      offer(item);
    end
    idle_cycles(1);

    // Let the outstanding results come out, then watch a little longer for
    // stray transfers.
    wait_cycles = 0;
    while (sb.outstanding() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.outstanding()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.error_count == 0)
      $display("tb_bytecode_operand_stack_top: clean");
    else
      $display("tb_bytecode_operand_stack_top: errors");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_bytecode_operand_stack_top: errors");
    $finish;
  end

endmodule
